[hdl/ctdsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctdsm_pkg
// Shared types and constants of the clock time/date set menu.
// ----------------------------------------------------------------------------
package ctdsm_pkg;

  // Menu state, also the code shown on the mode output
  typedef enum logic [2:0] {
    MODE_CLOCK     = 3'd0,
    MODE_MENU      = 3'd1,
    MODE_HOUR      = 3'd2,
    MODE_MINUTE    = 3'd3,
    MODE_DAY       = 3'd4,
    MODE_MONTH     = 3'd5,
    MODE_YEAR      = 3'd6,
    MODE_NET_RESET = 3'd7
  } mode_t;

  // Button events; codes above KEY_BACK are treated as no button
  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_UP     = 3'd1,
    KEY_DOWN   = 3'd2,
    KEY_SELECT = 3'd3,
    KEY_BACK   = 3'd4
  } btn_t;

  // Main menu entries
  typedef enum logic [1:0] {
    ITEM_TIME      = 2'd0,
    ITEM_DATE      = 2'd1,
    ITEM_NET_RESET = 2'd2
  } menu_item_t;

  localparam logic [15:0] BLINK_PERIOD_RESET = 16'd500;

  localparam logic [6:0]  HOURS_PER_DAY   = 7'd24;
  localparam logic [6:0]  MINS_PER_HOUR   = 7'd60;
  localparam logic [11:0] DAY_MIN         = 12'd1;
  localparam logic [11:0] DAY_MAX         = 12'd31;
  localparam logic [11:0] MONTH_MIN       = 12'd1;
  localparam logic [11:0] MONTH_MAX       = 12'd12;
  localparam logic [11:0] YEAR_MIN        = 12'd2000;
  localparam logic [11:0] YEAR_MAX        = 12'd2099;

endpackage : ctdsm_pkg
`default_nettype wire

[hdl/clock_time_date_set_menu_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted input beat passes the input register, then the result
//   register, before its result beat is on the output.
// Throughput: one beat per cycle while out_stall is low; the menu update is a single
//   pass of short logic between the input register and the result register.
// Reset: rst is synchronous, active high; it empties both registers, puts the
//   menu in clock view and loads the blink period with 500 ms.
// ----------------------------------------------------------------------------
// clock_time_date_set_menu_core
// Time/date set menu of a digital clock: blink timer, menu state machine,
// wrapping field editors and commit of the edited time or date.
// ----------------------------------------------------------------------------
module clock_time_date_set_menu_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: blink half period in ms
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  button,
  input  wire logic [31:0] now_ms,
  input  wire logic [4:0]  rtc_hour,
  input  wire logic [5:0]  rtc_minute,
  input  wire logic [5:0]  rtc_second,
  input  wire logic [4:0]  rtc_day,
  input  wire logic [3:0]  rtc_month,
  input  wire logic [11:0] rtc_year,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       mode,
  output logic [1:0]       menu_item,
  output logic             blink_on,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [4:0]       out_day,
  output logic [3:0]       out_month,
  output logic [11:0]      out_year,
  output logic             commit,
  output logic             net_reset_request
);

  import ctdsm_pkg::*;

  // Step a field by one in the button's direction, then fold it back into
  // lo..hi: below lo becomes hi, above hi becomes lo. The fold applies on
  // every event in a date edit mode, so an out-of-range value recovers even without a press.
  function automatic logic [11:0] step_ranged(
    input logic [11:0] v,
    input btn_t        b,
    input logic [11:0] lo,
    input logic [11:0] hi
  );
    logic signed [13:0] t;
    t = $signed({2'b00, v});
    if (b == KEY_UP)   t = t + 14'sd1;
    if (b == KEY_DOWN) t = t - 14'sd1;
    if (t < $signed({2'b00, lo})) t = $signed({2'b00, hi});
    if (t > $signed({2'b00, hi})) t = $signed({2'b00, lo});
    return t[11:0];
  endfunction

  // Reduce a value below three times m into 0..m-1 by two compare/subtracts
  function automatic logic [6:0] wrap_mod(input logic [6:0] t, input logic [6:0] m);
    logic [6:0] r;
    r = t;
    if (r >= m) r = r - m;
    if (r >= m) r = r - m;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: always ready; unenforced by the block, the user keeps it idle whenever it is written
  // --------------------------------------------------------------------------
  logic [15:0] blink_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= BLINK_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blink_period <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the result register advances when empty or when its beat is
  // taken; the input register then hands its beat on and takes a new one in
  // the same cycle.
  // --------------------------------------------------------------------------
  logic s_valid;
  logic advance;
  logic step;

  assign advance  = !out_valid || !out_stall;
  assign step     = s_valid && advance;
  assign in_stall = s_valid && !advance;

  // Input register: control bit resets, payload just holds
  logic [2:0]  s_button;
  logic [31:0] s_now_ms;
  logic [4:0]  s_rtc_hour;
  logic [5:0]  s_rtc_minute;
  logic [5:0]  s_rtc_second;
  logic [4:0]  s_rtc_day;
  logic [3:0]  s_rtc_month;
  logic [11:0] s_rtc_year;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_button     <= button;
      s_now_ms     <= now_ms;
      s_rtc_hour   <= rtc_hour;
      s_rtc_minute <= rtc_minute;
      s_rtc_second <= rtc_second;
      s_rtc_day    <= rtc_day;
      s_rtc_month  <= rtc_month;
      s_rtc_year   <= rtc_year;
    end
  end

  // --------------------------------------------------------------------------
  // Menu state
  // --------------------------------------------------------------------------
  mode_t       menu_mode, menu_mode_next;
  logic [1:0]  menu_pos, menu_pos_next;
  logic [4:0]  edit_hour, edit_hour_next;
  logic [5:0]  edit_minute, edit_minute_next;
  logic [4:0]  edit_day, edit_day_next;
  logic [3:0]  edit_month, edit_month_next;
  logic [11:0] edit_year, edit_year_next;
  logic [31:0] last_toggle, last_toggle_next;
  logic        blink, blink_next;

  // Unknown button codes act as no button
  btn_t btn;
  assign btn = (s_button > KEY_BACK) ? KEY_NONE : btn_t'(s_button);

  // Blink: toggle once the wrapped elapsed time exceeds the half period
  logic [31:0] elapsed;
  logic        toggle;

  assign elapsed          = s_now_ms - last_toggle;
  assign toggle           = elapsed > {16'd0, blink_period};
  assign last_toggle_next = toggle ? s_now_ms : last_toggle;
  assign blink_next       = blink ^ toggle;

  // Menu cursor: up moves toward the first entry, down toward the last
  always_comb begin
    case (btn)
      KEY_UP:   menu_pos_next = (menu_pos == ITEM_TIME) ? ITEM_NET_RESET : menu_pos - 2'd1;
      KEY_DOWN: menu_pos_next = (menu_pos >= ITEM_NET_RESET) ? ITEM_TIME : menu_pos + 2'd1;
      default:  menu_pos_next = (menu_pos > ITEM_NET_RESET) ? ITEM_TIME : menu_pos;
    endcase
  end

  // Next state
  always_comb begin
    menu_mode_next = menu_mode;
    case (menu_mode)
      MODE_CLOCK: begin
        if (btn == KEY_SELECT) menu_mode_next = MODE_MENU;
      end
      MODE_MENU: begin
        if (btn == KEY_SELECT) begin
          if (menu_pos == ITEM_TIME)      menu_mode_next = MODE_HOUR;
          else if (menu_pos == ITEM_DATE) menu_mode_next = MODE_DAY;
          else                            menu_mode_next = MODE_NET_RESET;
        end
      end
      MODE_HOUR: begin
        if (btn == KEY_SELECT) menu_mode_next = MODE_MINUTE;
        if (btn == KEY_BACK)   menu_mode_next = MODE_MENU;
      end
      MODE_MINUTE: begin
        if (btn == KEY_SELECT) menu_mode_next = MODE_CLOCK;
        if (btn == KEY_BACK)   menu_mode_next = MODE_MENU;
      end
      MODE_DAY: begin
        if (btn == KEY_SELECT) menu_mode_next = MODE_MONTH;
        if (btn == KEY_BACK)   menu_mode_next = MODE_MENU;
      end
      MODE_MONTH: begin
        if (btn == KEY_SELECT) menu_mode_next = MODE_YEAR;
        if (btn == KEY_BACK)   menu_mode_next = MODE_MENU;
      end
      MODE_YEAR: begin
        if (btn == KEY_SELECT) menu_mode_next = MODE_CLOCK;
        if (btn == KEY_BACK)   menu_mode_next = MODE_MENU;
      end
      default: begin
        // network reset: absorbing, only rst leaves it
        menu_mode_next = MODE_NET_RESET;
      end
    endcase
  end

  // Field editors and result values
  logic [2:0]  r_menu_item;
  logic [4:0]  r_hour;
  logic [5:0]  r_minute;
  logic [5:0]  r_second;
  logic [4:0]  r_day;
  logic [3:0]  r_month;
  logic [11:0] r_year;
  logic        r_commit;
  logic        r_net_req;
  logic [11:0] day_step, month_step, year_step;
  logic [6:0]  hour_up, hour_down, min_up, min_down;

  assign day_step   = step_ranged({7'd0, edit_day}, btn, DAY_MIN, DAY_MAX);
  assign month_step = step_ranged({8'd0, edit_month}, btn, MONTH_MIN, MONTH_MAX);
  assign year_step  = step_ranged(edit_year, btn, YEAR_MIN, YEAR_MAX);
  assign hour_up    = wrap_mod({2'd0, edit_hour} + 7'd1, HOURS_PER_DAY);
  assign hour_down  = wrap_mod({2'd0, edit_hour} + HOURS_PER_DAY - 7'd1, HOURS_PER_DAY);
  assign min_up     = wrap_mod({1'b0, edit_minute} + 7'd1, MINS_PER_HOUR);
  assign min_down   = wrap_mod({1'b0, edit_minute} + MINS_PER_HOUR - 7'd1, MINS_PER_HOUR);

  always_comb begin
    edit_hour_next   = edit_hour;
    edit_minute_next = edit_minute;
    edit_day_next    = edit_day;
    edit_month_next  = edit_month;
    edit_year_next   = edit_year;
    r_menu_item      = {1'b0, menu_pos};
    r_commit         = 1'b0;
    r_net_req        = 1'b0;
    case (menu_mode)
      MODE_CLOCK: begin
        if (btn == KEY_SELECT) begin
          // capture the clock reading as the starting point of an edit
          r_menu_item      = {1'b0, ITEM_TIME};
          edit_hour_next   = s_rtc_hour;
          edit_minute_next = s_rtc_minute;
          edit_day_next    = s_rtc_day;
          edit_month_next  = s_rtc_month;
          edit_year_next   = s_rtc_year;
        end
      end
      MODE_MENU: begin
        r_menu_item = {1'b0, menu_pos_next};
      end
      MODE_HOUR: begin
        if (btn == KEY_UP)   edit_hour_next = hour_up[4:0];
        if (btn == KEY_DOWN) edit_hour_next = hour_down[4:0];
      end
      MODE_MINUTE: begin
        if (btn == KEY_UP)     edit_minute_next = min_up[5:0];
        if (btn == KEY_DOWN)   edit_minute_next = min_down[5:0];
        if (btn == KEY_SELECT) r_commit = 1'b1;
      end
      MODE_DAY: begin
        edit_day_next = day_step[4:0];
      end
      MODE_MONTH: begin
        edit_month_next = month_step[3:0];
      end
      MODE_YEAR: begin
        edit_year_next = year_step;
        if (btn == KEY_SELECT) r_commit = 1'b1;
      end
      default: begin
        r_net_req = 1'b1;
      end
    endcase

    // Result fields: edited values, or the commit mix of edited and clock
    r_hour   = edit_hour_next;
    r_minute = edit_minute_next;
    r_second = 6'd0;
    r_day    = edit_day_next;
    r_month  = edit_month_next;
    r_year   = edit_year_next;
    if (r_commit && menu_mode == MODE_MINUTE) begin
      // new time, date taken from the clock
      r_day   = s_rtc_day;
      r_month = s_rtc_month;
      r_year  = s_rtc_year;
    end else if (r_commit) begin
      // new date, time taken from the clock
      r_hour   = s_rtc_hour;
      r_minute = s_rtc_minute;
      r_second = s_rtc_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_mode   <= MODE_CLOCK;
      menu_pos    <= ITEM_TIME;
      edit_hour   <= 5'd0;
      edit_minute <= 6'd0;
      edit_day    <= 5'd1;
      edit_month  <= 4'd1;
      edit_year   <= YEAR_MIN;
      last_toggle <= 32'd0;
      blink       <= 1'b1;
    end else if (step) begin
      menu_mode   <= menu_mode_next;
      menu_pos    <= r_menu_item[1:0];
      edit_hour   <= edit_hour_next;
      edit_minute <= edit_minute_next;
      edit_day    <= edit_day_next;
      edit_month  <= edit_month_next;
      edit_year   <= edit_year_next;
      last_toggle <= last_toggle_next;
      blink       <= blink_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold the beat until the consumer takes it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mode              <= menu_mode_next;
      menu_item         <= r_menu_item[1:0];
      blink_on          <= blink_next;
      out_hour          <= r_hour;
      out_minute        <= r_minute;
      out_second        <= r_second;
      out_day           <= r_day;
      out_month         <= r_month;
      out_year          <= r_year;
      commit            <= r_commit;
      net_reset_request <= r_net_req;
    end
  end

endmodule : clock_time_date_set_menu_core
`default_nettype wire

[hdl/ctdsm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctdsm_checker
// Port-level checks of the clock time/date set menu, bound to the top level.
// ----------------------------------------------------------------------------
module ctdsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  mode,
  input wire logic [1:0]  menu_item,
  input wire logic [5:0]  out_second,
  input wire logic        commit,
  input wire logic        net_reset_request
);

  import ctdsm_pkg::*;

  // A stalled result beat stays and holds its state fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode) && $stable(menu_item)
      && $stable(commit))
    else $error("result beat changed while stalled");

  // A commit always sends the menu back to clock view
  a_commit_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && commit |-> mode == MODE_CLOCK)
    else $error("commit outside clock view");

  // The network reset request only comes from network reset mode
  a_net_req_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && net_reset_request |-> mode == MODE_NET_RESET && !commit)
    else $error("network reset request in wrong mode");

  // Seconds are only carried by a commit
  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !commit |-> out_second == 6'd0)
    else $error("nonzero second without commit");

endmodule : ctdsm_checker

bind clock_time_date_set_menu_core ctdsm_checker u_ctdsm_checker (.*);
`default_nettype wire

[bench/clock_time_date_set_menu_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_time_date_set_menu_core_test
// Self-checking bench for the time/date set menu. An initial block plans the
// event beats phase by phase, each phase under its own blink period and one of
// four idle/stall profiles; it walks a shadow menu so the random buttons follow
// real edit sequences. The driver predicts every accepted beat; the monitor
// compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module clock_time_date_set_menu_core_test;
  import ctdsm_pkg::*;

  localparam int PHASES        = 7;
  localparam int PHASE_EVENTS  = 130;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [31:0] WALK_GAP = 32'd200;

  // Button codes past KEY_BACK that the block must treat as no button
  localparam logic [2:0] BTN_SPARE_FIRST = 3'(KEY_BACK + 1);
  localparam logic [2:0] BTN_SPARE_LAST  = 3'b111;

  // One input beat: button, timestamp and the clock reading
  typedef struct packed {
    logic [2:0]  button;
    logic [31:0] now_ms;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } clock_event_t;

  // One result beat, fields in port order
  typedef struct packed {
    mode_t       mode;
    menu_item_t  item;
    logic        blink;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic        commit;
    logic        net_req;
  } menu_view_t;

  // Menu state plus the blink period register
  typedef struct packed {
    mode_t       mode;
    menu_item_t  position;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [31:0] last_toggle;
    logic        blink;
    logic [15:0] period;
  } menu_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  button = '0;
  logic [31:0] now_ms = '0;
  logic [4:0]  rtc_hour = '0;
  logic [5:0]  rtc_minute = '0;
  logic [5:0]  rtc_second = '0;
  logic [4:0]  rtc_day = '0;
  logic [3:0]  rtc_month = '0;
  logic [11:0] rtc_year = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  mode;
  logic [1:0]  menu_item;
  logic        blink_on;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [11:0] out_year;
  logic        commit;
  logic        net_reset_request;

  menu_state_t  expect_menu;        // advanced on accepted beats
  menu_state_t  plan_menu;          // advanced as beats are planned
  clock_event_t reading;            // clock reading used by the directed beats
  clock_event_t in_flight;          // beat currently on the input port
  logic [31:0]  last_stamp = '0;
  clock_event_t events_to_send[$];
  menu_view_t   predicted_views[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  clock_time_date_set_menu_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .button(button), .now_ms(now_ms),
    .rtc_hour(rtc_hour), .rtc_minute(rtc_minute), .rtc_second(rtc_second),
    .rtc_day(rtc_day), .rtc_month(rtc_month), .rtc_year(rtc_year),
    .out_valid(out_valid), .out_stall(out_stall), .mode(mode), .menu_item(menu_item),
    .blink_on(blink_on), .out_hour(out_hour), .out_minute(out_minute),
    .out_second(out_second), .out_day(out_day), .out_month(out_month),
    .out_year(out_year), .commit(commit), .net_reset_request(net_reset_request)
  );

  always #2 clk = ~clk;

  function automatic menu_state_t menu_reset();
    menu_state_t s;
    s.mode        = MODE_CLOCK;
    s.position    = ITEM_TIME;
    s.hour        = '0;
    s.minute      = '0;
    s.day         = 5'(DAY_MIN);
    s.month       = 4'(MONTH_MIN);
    s.year        = YEAR_MIN;
    s.last_toggle = '0;
    s.blink       = 1'b1;
    s.period      = BLINK_PERIOD_RESET;
    return s;
  endfunction

  // Step a bounded field; anything outside [lo, hi] wraps to the far end
  function automatic int wrap_field(int v, btn_t b, int lo, int hi);
    if (b == KEY_UP) v++;
    if (b == KEY_DOWN) v--;
    if (v < lo) v = hi;
    if (v > hi) v = lo;
    return v;
  endfunction

  // Advance the menu by one event and return the result beat it produces
  function automatic menu_view_t advance_menu(inout menu_state_t s, input clock_event_t e);
    btn_t        b;
    btn_t        toward;
    logic [31:0] elapsed;
    menu_view_t  v;
    b = (e.button > KEY_BACK) ? KEY_NONE : btn_t'(e.button);
    v = '0;

    // Toggle once the wrapped elapsed time exceeds the period
    elapsed = e.now_ms - s.last_toggle;
    if (elapsed > {16'd0, s.period}) begin
      s.last_toggle = e.now_ms;
      s.blink = ~s.blink;
    end

    case (s.mode)
      MODE_CLOCK: begin
        if (b == KEY_SELECT) begin
          s.position = ITEM_TIME;
          s.hour     = e.hour;
          s.minute   = e.minute;
          s.day      = e.day;
          s.month    = e.month;
          s.year     = e.year;
          s.mode     = MODE_MENU;
        end
      end
      MODE_MENU: begin
        // Up moves the highlight toward the first entry
        toward = (b == KEY_UP) ? KEY_DOWN : ((b == KEY_DOWN) ? KEY_UP : KEY_NONE);
        s.position = menu_item_t'(wrap_field(int'(s.position), toward,
                                             ITEM_TIME, ITEM_NET_RESET));
        if (b == KEY_SELECT) begin
          case (s.position)
            ITEM_TIME: s.mode = MODE_HOUR;
            ITEM_DATE: s.mode = MODE_DAY;
            default:   s.mode = MODE_NET_RESET;
          endcase
        end
      end
      MODE_HOUR: begin
        if (b == KEY_UP)
          s.hour = 5'((int'(s.hour) + 1) % int'(HOURS_PER_DAY));
        if (b == KEY_DOWN)
          s.hour = 5'((int'(s.hour) + int'(HOURS_PER_DAY) - 1) % int'(HOURS_PER_DAY));
        if (b == KEY_SELECT) s.mode = MODE_MINUTE;
        if (b == KEY_BACK) s.mode = MODE_MENU;
      end
      MODE_MINUTE: begin
        if (b == KEY_UP)
          s.minute = 6'((int'(s.minute) + 1) % int'(MINS_PER_HOUR));
        if (b == KEY_DOWN)
          s.minute = 6'((int'(s.minute) + int'(MINS_PER_HOUR) - 1) % int'(MINS_PER_HOUR));
        if (b == KEY_SELECT) begin
          // Commit the edited time with the clock's own date
          v.commit = 1'b1;
          v.hour   = s.hour;
          v.minute = s.minute;
          v.day    = e.day;
          v.month  = e.month;
          v.year   = e.year;
          s.mode   = MODE_CLOCK;
        end
        if (b == KEY_BACK) s.mode = MODE_MENU;
      end
      MODE_DAY: begin
        s.day = 5'(wrap_field(int'(s.day), b, int'(DAY_MIN), int'(DAY_MAX)));
        if (b == KEY_SELECT) s.mode = MODE_MONTH;
        if (b == KEY_BACK) s.mode = MODE_MENU;
      end
      MODE_MONTH: begin
        s.month = 4'(wrap_field(int'(s.month), b, int'(MONTH_MIN), int'(MONTH_MAX)));
        if (b == KEY_SELECT) s.mode = MODE_YEAR;
        if (b == KEY_BACK) s.mode = MODE_MENU;
      end
      MODE_YEAR: begin
        s.year = 12'(wrap_field(int'(s.year), b, int'(YEAR_MIN), int'(YEAR_MAX)));
        if (b == KEY_SELECT) begin
          // Commit the edited date with the clock's own time
          v.commit = 1'b1;
          v.hour   = e.hour;
          v.minute = e.minute;
          v.second = e.second;
          v.day    = s.day;
          v.month  = s.month;
          v.year   = s.year;
          s.mode   = MODE_CLOCK;
        end
        if (b == KEY_BACK) s.mode = MODE_MENU;
      end
      default: v.net_req = 1'b1;
    endcase

    if (!v.commit) begin
      v.hour   = s.hour;
      v.minute = s.minute;
      v.day    = s.day;
      v.month  = s.month;
      v.year   = s.year;
    end
    v.mode  = s.mode;
    v.item  = s.position;
    v.blink = s.blink;
    return v;
  endfunction

  function automatic string show_view(menu_view_t v);
    return $sformatf("mode=%0d item=%0d blink=%0b %0d:%0d:%0d %0d/%0d/%0d commit=%0b net=%0b",
                     v.mode, v.item, v.blink, v.hour, v.minute, v.second,
                     v.day, v.month, v.year, v.commit, v.net_req);
  endfunction

  // Plan a beat: walk the shadow menu and hand the beat to the driver
  task automatic queue_event(input clock_event_t e);
    void'(advance_menu(plan_menu, e));
    last_stamp = e.now_ms;
    events_to_send.push_back(e);
  endtask

  task automatic directed(input logic [2:0] b, input logic [31:0] stamp);
    clock_event_t e;
    e = reading;
    e.button = b;
    e.now_ms = stamp;
    queue_event(e);
  endtask

  // Random beat steered by the shadow menu so edits run to their commits.
  // Entering network reset is held back until the last phase: nothing but
  // a reset leaves that mode.
  function automatic clock_event_t random_event(bit allow_net_reset);
    clock_event_t e;
    int           r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      e.button = 3'($urandom_range(0, 7));
    end else begin
      case (plan_menu.mode)
        MODE_CLOCK: begin
          if (r < 60) e.button = KEY_SELECT;
          else e.button = 3'($urandom_range(KEY_NONE, KEY_BACK));
        end
        MODE_MENU: begin
          if (r < 40) e.button = KEY_UP;
          else if (r < 65) e.button = KEY_DOWN;
          else e.button = KEY_SELECT;
        end
        default: begin
          if (r < 42) e.button = KEY_UP;
          else if (r < 70) e.button = KEY_DOWN;
          else if (r < 90) e.button = KEY_SELECT;
          else e.button = KEY_BACK;
        end
      endcase
    end
    if (!allow_net_reset && plan_menu.mode == MODE_MENU &&
        plan_menu.position == ITEM_NET_RESET && e.button == KEY_SELECT)
      e.button = KEY_DOWN;

    // Mostly steps around the period, with exact boundaries and wild jumps
    case ($urandom_range(0, 7))
      0:       e.now_ms = last_stamp;
      1:       e.now_ms = last_stamp + plan_menu.period;
      2:       e.now_ms = last_stamp + plan_menu.period + 32'd1;
      3:       e.now_ms = $urandom();
      default: e.now_ms = last_stamp + $urandom_range(0, 2 * plan_menu.period + 2);
    endcase

    if ($urandom_range(0, 9) == 0) begin
      // Raw readings at full width, out of range included
      e.hour   = 5'($urandom);
      e.minute = 6'($urandom);
      e.second = 6'($urandom);
      e.day    = 5'($urandom);
      e.month  = 4'($urandom);
      e.year   = 12'($urandom);
    end else begin
      e.hour   = 5'($urandom_range(0, 23));
      e.minute = 6'($urandom_range(0, 59));
      e.second = 6'($urandom_range(0, 59));
      e.day    = 5'($urandom_range(DAY_MIN, DAY_MAX));
      e.month  = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
      e.year   = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
    end
    return e;
  endfunction

  // Driver: predict the beat accepted at this edge, then present the next one.
  // Hold valid and payload steady while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predicted_views.push_back(advance_menu(expect_menu, in_flight));
      if (!in_valid || !in_stall) begin
        if (events_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight = events_to_send.pop_front();
          in_valid   <= 1'b1;
          button     <= in_flight.button;
          now_ms     <= in_flight.now_ms;
          rtc_hour   <= in_flight.hour;
          rtc_minute <= in_flight.minute;
          rtc_second <= in_flight.second;
          rtc_day    <= in_flight.day;
          rtc_month  <= in_flight.month;
          rtc_year   <= in_flight.year;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result beat against the oldest prediction
  always @(posedge clk) begin : monitor
    menu_view_t seen;
    menu_view_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {mode, menu_item, blink_on, out_hour, out_minute, out_second,
                out_day, out_month, out_year, commit, net_reset_request};
        if (predicted_views.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("result beat with nothing predicted: %s", show_view(seen));
          mismatches++;
        end else begin
          want = predicted_views.pop_front();
          if (seen !== want) begin
            if (mismatches < REPORT_LIMIT)
              $display("result mismatch: expected %s / actual %s",
                       show_view(want), show_view(seen));
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run with errors once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("clock_time_date_set_menu_core_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int unsigned period;
    expect_menu = menu_reset();
    plan_menu   = menu_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
      case (p)
        0:       period = BLINK_PERIOD_RESET;
        1:       period = 0;
        2:       period = 1;
        3:       period = 16'hFFFF;
        4:       period = $urandom_range(2, 2000);
        default: period = $urandom_range(1, 65535);
      endcase

      // Write the blink period while the block is idle
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= 16'(period);
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      expect_menu.period = 16'(period);
      plan_menu.period   = 16'(period);

      if (p == 0) begin
        reading = {3'd0, 32'd0, 5'd0, 6'd0, 6'd0, 5'd31, 4'd12, 12'd2099};
        // Blink boundary: exactly the period holds, one past it toggles
        directed(KEY_NONE, 32'd0);
        directed(BTN_SPARE_FIRST, 32'd500);
        directed(BTN_SPARE_LAST, 32'd501);
        // Huge jump, then a short step across the timestamp wrap
        directed(3'(BTN_SPARE_FIRST + 1), 32'hFFFF_FFF0);
        directed(KEY_BACK, 32'd16);
        // Time edit from midnight: wrap the menu, hour and minute downward
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        directed(KEY_UP, last_stamp + WALK_GAP);
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        directed(KEY_UP, last_stamp + WALK_GAP);
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        // Commit with an out-of-range clock date, then capture that reading
        reading = {3'd0, 32'd0, 5'd31, 6'd63, 6'd63, 5'd0, 4'd15, 12'd4095};
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        // Date edit: bring day, month and year back into range both ways
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        directed(KEY_UP, last_stamp + WALK_GAP);
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        directed(KEY_UP, last_stamp + WALK_GAP);
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        directed(KEY_SELECT, last_stamp + WALK_GAP);
        directed(KEY_UP, last_stamp + WALK_GAP);
        directed(KEY_DOWN, last_stamp + WALK_GAP);
        directed(KEY_BACK, last_stamp + WALK_GAP);
      end

      repeat (PHASE_EVENTS) queue_event(random_event(p == PHASES - 1));

      // Drain: every beat sent, every result back, then let the pipe settle
      do @(posedge clk);
      while (events_to_send.size() != 0 || in_valid || predicted_views.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatches == 0) begin
      $display("clock_time_date_set_menu_core_test: clean");
    end else begin
      $display("clock_time_date_set_menu_core_test: errors");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ctdsm_pkg.sv
hdl/clock_time_date_set_menu_core.sv
hdl/ctdsm_checker.sv
bench/clock_time_date_set_menu_core_test.sv
